@@ rtl/rtti_pkg.sv @@
package rtti_pkg;

    // Fixed field widths.
    localparam int CHAR_W   = 8;
    localparam int RADIX_W  = 6;
    localparam int DIGIT_W  = 6;
    localparam int END_W    = 13;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 1'd1;

    // Register reset values.
    localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
    localparam logic               SIGNED_RESET = 1'b1;

    // Radix codes with a meaning of their own.
    localparam logic [RADIX_W-1:0] RADIX_AUTO    = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_UNUSED  = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCTAL   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX     = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_X   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [DIGIT_W-1:0] LETTER_BASE = 6'd10;

    // Parser phase, one-hot.
    typedef enum logic [6:0] {
        PH_SPACE  = 7'b0000001,
        PH_SIGNED = 7'b0000010,
        PH_ZERO   = 7'b0000100,
        PH_HEXPFX = 7'b0001000,
        PH_DIGITS = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_BAD    = 7'b1000000
    } phase_t;

    // Classification of one byte.
    typedef struct packed {
        logic               blank;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
    } char_class_t;

endpackage

@@ rtl/rtti_char_decode.sv @@
module rtti_char_decode (
    input  logic [rtti_pkg::CHAR_W-1:0] char_code,
    output rtti_pkg::char_class_t       char_class
);

    logic [rtti_pkg::CHAR_W-1:0] offset;

    always_comb
    begin
        char_class.blank    = (char_code == rtti_pkg::CH_SPACE) ||
                              (char_code inside {[rtti_pkg::CH_TAB:rtti_pkg::CH_CR]});
        char_class.is_digit = 1'b1;
        offset              = '0;
        char_class.digit    = '0;
        if (char_code inside {[rtti_pkg::CH_ZERO:rtti_pkg::CH_NINE]})
        begin
            offset           = char_code - rtti_pkg::CH_ZERO;
            char_class.digit = offset[rtti_pkg::DIGIT_W-1:0];
        end
        else if (char_code inside {[rtti_pkg::CH_UP_A:rtti_pkg::CH_UP_Z]})
        begin
            offset           = char_code - rtti_pkg::CH_UP_A;
            char_class.digit = offset[rtti_pkg::DIGIT_W-1:0] + rtti_pkg::LETTER_BASE;
        end
        else if (char_code inside {[rtti_pkg::CH_LO_A:rtti_pkg::CH_LO_Z]})
        begin
            offset           = char_code - rtti_pkg::CH_LO_A;
            char_class.digit = offset[rtti_pkg::DIGIT_W-1:0] + rtti_pkg::LETTER_BASE;
        end
        else
        begin
            char_class.is_digit = 1'b0;
        end
    end

endmodule

@@ rtl/rtti_parse_core.sv @@
module rtti_parse_core #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_LEN     = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [rtti_pkg::CHAR_W-1:0]   char_code,
    input  logic                          last_char,
    input  logic [rtti_pkg::RADIX_W-1:0]  radix_cfg,
    input  logic                          signed_cfg,
    output logic [VALUE_WIDTH-1:0]        res_value,
    output logic [rtti_pkg::END_W-1:0]    res_end_pos,
    output logic                          res_any_digit,
    output logic                          res_overflowed
);

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int MUL_W = VALUE_WIDTH + rtti_pkg::RADIX_W;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);

    rtti_pkg::phase_t phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0]       accum_reg, accum_next;
    logic                         negative_reg, negative_next;
    logic                         digit_seen_reg, digit_seen_next;
    logic                         overflow_seen_reg, overflow_seen_next;
    logic [rtti_pkg::RADIX_W-1:0] working_radix_reg, working_radix_next;
    logic [POS_W-1:0]             byte_pos_reg, byte_pos_next;
    logic [POS_W-1:0]             end_mark_reg, end_mark_next;

    rtti_pkg::char_class_t        cls;
    rtti_pkg::phase_t             phase_cur;
    logic [rtti_pkg::RADIX_W-1:0] radix_cur;
    logic [rtti_pkg::RADIX_W-1:0] mul_radix;
    logic [MUL_W-1:0]             product;
    logic                         first_zero;
    logic                         use_digit;
    logic                         radix_bad;
    logic [VALUE_WIDTH-1:0]       neg_mag;
    logic [POS_W+rtti_pkg::END_W-1:0] end_ext;

    rtti_char_decode u_decode (
        .char_code  (char_code),
        .char_class (cls)
    );

    assign radix_bad = (radix_cfg == rtti_pkg::RADIX_UNUSED) ||
                       (radix_cfg > rtti_pkg::RADIX_MAX);

    // Radix and phase as seen by this byte: the radix is latched on the
    // first byte of every string.
    always_comb
    begin
        phase_cur = phase_reg;
        radix_cur = working_radix_reg;
        if (byte_pos_reg == '0)
        begin
            if (radix_bad)
            begin
                phase_cur = rtti_pkg::PH_BAD;
                radix_cur = '0;
            end
            else
            begin
                radix_cur = radix_cfg;
            end
        end
    end

    // A leading zero in auto or hex mode may still start a 0x prefix.
    assign first_zero = (char_code == rtti_pkg::CH_ZERO) &&
                        ((radix_cur == rtti_pkg::RADIX_AUTO) ||
                         (radix_cur == rtti_pkg::RADIX_HEX));

    // The radix a digit is taken in, after auto-detection settles it.
    always_comb
    begin
        mul_radix = radix_cur;
        if (radix_cur == rtti_pkg::RADIX_AUTO)
        begin
            if (phase_cur == rtti_pkg::PH_ZERO)
                mul_radix = rtti_pkg::RADIX_OCTAL;
            else
                mul_radix = rtti_pkg::RADIX_DECIMAL;
        end
    end

    assign product = MUL_W'(accum_reg) * MUL_W'(mul_radix) + MUL_W'(cls.digit);

    always_comb
    begin
        phase_next         = phase_cur;
        accum_next         = accum_reg;
        negative_next      = negative_reg;
        digit_seen_next    = digit_seen_reg;
        overflow_seen_next = overflow_seen_reg;
        working_radix_next = radix_cur;
        byte_pos_next      = byte_pos_reg;
        end_mark_next      = end_mark_reg;
        use_digit          = 1'b0;

        if (byte_pos_reg < POS_LIMIT)
        begin
            byte_pos_next = byte_pos_reg + 1'b1;
            case (phase_cur)
                rtti_pkg::PH_SPACE, rtti_pkg::PH_SIGNED:
                begin
                    if (phase_cur == rtti_pkg::PH_SPACE && cls.blank)
                    begin
                        phase_next = rtti_pkg::PH_SPACE;
                    end
                    else if (phase_cur == rtti_pkg::PH_SPACE &&
                             char_code == rtti_pkg::CH_MINUS)
                    begin
                        negative_next = 1'b1;
                        phase_next    = rtti_pkg::PH_SIGNED;
                    end
                    else if (phase_cur == rtti_pkg::PH_SPACE &&
                             char_code == rtti_pkg::CH_PLUS)
                    begin
                        phase_next = rtti_pkg::PH_SIGNED;
                    end
                    else if (first_zero)
                    begin
                        digit_seen_next = 1'b1;
                        end_mark_next   = byte_pos_reg + 1'b1;
                        accum_next      = '0;
                        phase_next      = rtti_pkg::PH_ZERO;
                    end
                    else
                    begin
                        working_radix_next = mul_radix;
                        use_digit          = 1'b1;
                    end
                end
                rtti_pkg::PH_ZERO:
                begin
                    if (char_code == rtti_pkg::CH_LO_X || char_code == rtti_pkg::CH_UP_X)
                    begin
                        working_radix_next = rtti_pkg::RADIX_HEX;
                        phase_next         = rtti_pkg::PH_HEXPFX;
                    end
                    else
                    begin
                        working_radix_next = mul_radix;
                        use_digit          = 1'b1;
                    end
                end
                rtti_pkg::PH_HEXPFX, rtti_pkg::PH_DIGITS:
                begin
                    use_digit = 1'b1;
                end
                default:
                begin
                    phase_next = phase_cur;
                end
            endcase

            if (use_digit)
            begin
                if (mul_radix < rtti_pkg::RADIX_MIN || !cls.is_digit ||
                    cls.digit >= mul_radix)
                begin
                    phase_next = rtti_pkg::PH_DONE;
                end
                else
                begin
                    digit_seen_next = 1'b1;
                    end_mark_next   = byte_pos_reg + 1'b1;
                    phase_next      = rtti_pkg::PH_DIGITS;
                    if (!overflow_seen_reg)
                    begin
                        if (product[MUL_W-1:VALUE_WIDTH] == '0)
                            accum_next = product[VALUE_WIDTH-1:0];
                        else
                            overflow_seen_next = 1'b1;
                    end
                end
            end
        end
    end

    // Result of a string, formed from the state after its final byte.
    assign neg_mag = ~accum_next + 1'b1;
    assign end_ext = {{rtti_pkg::END_W{1'b0}}, end_mark_next};

    always_comb
    begin
        res_value      = '0;
        res_end_pos    = '0;
        res_any_digit  = 1'b0;
        res_overflowed = 1'b0;
        if (digit_seen_next && phase_next != rtti_pkg::PH_BAD)
        begin
            res_any_digit = 1'b1;
            res_end_pos   = end_ext[rtti_pkg::END_W-1:0];
            if (!signed_cfg)
            begin
                res_overflowed = overflow_seen_next;
                if (overflow_seen_next)
                    res_value = '1;
                else
                    res_value = negative_next ? neg_mag : accum_next;
            end
            else if (overflow_seen_next ||
                     (negative_next ? (accum_next[VALUE_WIDTH-1] &&
                                       (|accum_next[VALUE_WIDTH-2:0]))
                                    : accum_next[VALUE_WIDTH-1]))
            begin
                res_overflowed = 1'b1;
                res_value      = negative_next ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                               : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            end
            else
            begin
                res_value = negative_next ? neg_mag : accum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= rtti_pkg::PH_SPACE;
            accum_reg         <= '0;
            negative_reg      <= 1'b0;
            digit_seen_reg    <= 1'b0;
            overflow_seen_reg <= 1'b0;
            working_radix_reg <= '0;
            byte_pos_reg      <= '0;
            end_mark_reg      <= '0;
        end
        else if (step)
        begin
            if (last_char)
            begin
                phase_reg         <= rtti_pkg::PH_SPACE;
                accum_reg         <= '0;
                negative_reg      <= 1'b0;
                digit_seen_reg    <= 1'b0;
                overflow_seen_reg <= 1'b0;
                working_radix_reg <= '0;
                byte_pos_reg      <= '0;
                end_mark_reg      <= '0;
            end
            else
            begin
                phase_reg         <= phase_next;
                accum_reg         <= accum_next;
                negative_reg      <= negative_next;
                digit_seen_reg    <= digit_seen_next;
                overflow_seen_reg <= overflow_seen_next;
                working_radix_reg <= working_radix_next;
                byte_pos_reg      <= byte_pos_next;
                end_mark_reg      <= end_mark_next;
            end
        end
    end

endmodule

@@ rtl/radix_text_to_integer_top.sv @@
// Streaming text-to-integer parser. Bytes of a string arrive on the input
// channel (in_valid / in_stall) one per transfer, with last_char set on the
// final byte. Leading whitespace is skipped, an optional sign is noted, and
// digits are accumulated in the configured radix with saturation on overflow.
// Each string yields exactly one transfer on the output channel
// (out_valid / out_stall), carrying value, end_pos, any_digit and overflowed.
// Throughput is one byte per cycle: the input register feeds one pass of
// decode, a 6-bit by VALUE_WIDTH multiply-add and the saturation logic,
// which updates the parser state and loads the result register in the same
// cycle. out_valid rises when the final byte's result is loaded into the
// result register, and the result transfers while out_stall is low. When
// the receiver stalls, the result register holds its item and non-final
// bytes keep flowing; only a final byte waits in the input register, and
// in_stall rises until the result register frees up.
// The configuration channel (cfg_valid / cfg_ready) is always ready and
// should only be written while no string is in progress. Reset clears the
// parser state, empties both registers and sets radix 10, signed mode.
module radix_text_to_integer_top #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_LEN     = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rtti_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtti_pkg::RADIX_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rtti_pkg::CHAR_W-1:0]     char_code,
    input  logic                            last_char,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [VALUE_WIDTH-1:0]          value,
    output logic [rtti_pkg::END_W-1:0]      end_pos,
    output logic                            any_digit,
    output logic                            overflowed
);

    logic [rtti_pkg::RADIX_W-1:0] radix_reg;
    logic                         signed_mode_reg;

    logic                         s1_valid_reg, s1_valid_next;
    logic [rtti_pkg::CHAR_W-1:0]  s1_char_reg;
    logic                         s1_last_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0]       value_reg;
    logic [rtti_pkg::END_W-1:0]   end_pos_reg;
    logic                         any_digit_reg;
    logic                         overflowed_reg;

    logic                         out_free;
    logic                         step;
    logic                         accept;

    logic [VALUE_WIDTH-1:0]       res_value;
    logic [rtti_pkg::END_W-1:0]   res_end_pos;
    logic                         res_any_digit;
    logic                         res_overflowed;

    // Configuration registers; the write channel never back-pressures.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= rtti_pkg::RADIX_RESET;
            signed_mode_reg <= rtti_pkg::SIGNED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rtti_pkg::CFG_RADIX:  radix_reg       <= cfg_data;
                rtti_pkg::CFG_SIGNED: signed_mode_reg <= cfg_data[0];
                default:              radix_reg       <= radix_reg;
            endcase
        end
    end

    // A byte in the input register is processed unless it is a final byte
    // and the result register is still occupied by an untaken result.
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !step;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (step)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= last_char;
        end
    end

    rtti_parse_core #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_LEN     (MAX_LEN)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .char_code      (s1_char_reg),
        .last_char      (s1_last_reg),
        .radix_cfg      (radix_reg),
        .signed_cfg     (signed_mode_reg),
        .res_value      (res_value),
        .res_end_pos    (res_end_pos),
        .res_any_digit  (res_any_digit),
        .res_overflowed (res_overflowed)
    );

    // Result register: loaded by a final byte, emptied by a transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && s1_last_reg)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && s1_last_reg)
        begin
            value_reg      <= res_value;
            end_pos_reg    <= res_end_pos;
            any_digit_reg  <= res_any_digit;
            overflowed_reg <= res_overflowed;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign end_pos    = end_pos_reg;
    assign any_digit  = any_digit_reg;
    assign overflowed = overflowed_reg;

endmodule
